@@ src/bcle_pkg.sv @@
// Shared types and constants for the bounded circular list engine.
`default_nettype none

package bcle_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HeldW   = 5;
  // Cell index field of the command; wide enough for the largest supported depth.
  localparam int unsigned IdxW    = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_END   = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_END   = 3'd3,
    MODE_DEL_POS   = 3'd4,
    MODE_READ_OUT  = 3'd5
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  // Operation broadcast to every cell of the chain at once.
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_APPEND     = 3'd2,
    OP_CLOSE_GAP  = 3'd3,
    OP_ROTATE     = 3'd4
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [IdxW-1:0]          idx;
    logic signed [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ src/bounded_circular_list_engine_core.sv @@
// Top level of the bounded circular list engine: control, cell chain and output register.
//
// Input items arrive on the s_axis channel: tuser carries the operation mode,
// tdata the value to insert and the 1-based delete position. Results leave on
// the m_axis channel: tdata carries the entry value and the entry count, tuser
// the status, and tlast marks the final result of an input item.
// The list lives in a chain of DEPTH cells, cell k holding the k-th entry.
// A front insert, a front delete and a delete by position are done by the cells
// all copying a neighbor at once; an append writes only the tail cell and a
// delete at the end only lowers the count. Each gives one result, registered
// in the cycle after the input transfer. Read out rotates the chain one cell
// per cycle while the receiver takes results and emits the head each time: a
// list of N entries gives N results, and after N rotations the order is back
// where it started. Input is taken again once the last result is registered.
// The output register lets a new input be taken as its held result is accepted.
// When the receiver stalls, the held result stays and read out pauses with it.
// Reset empties the list at once; cell contents need no clearing.
`default_nettype none

module bounded_circular_list_engine_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] value, [39:32] position
  input  wire [39:0]  s_axis_tdata_i,
  // [2:0] mode
  input  wire [2:0]   s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [31:0] item_value, [36:32] entries_held, [39:37] zero
  output logic [39:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import bcle_pkg::*;

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = ((CW > PosW) ? CW : PosW) + 1;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            rd_left_q, rd_left_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] out_value_q, out_value_d;
  status_e                  out_status_q, out_status_d;
  logic [HeldW-1:0]         out_held_q, out_held_d;
  logic                     out_last_q, out_last_d;

  cell_cmd_t                cell_cmd;
  logic signed [ValueW-1:0] cell_value [DEPTH];

  logic                     out_free;
  logic                     in_fire;
  mode_e                    in_mode;
  logic signed [ValueW-1:0] in_value;
  logic [PosW-1:0]          in_pos;
  logic                     ld;
  logic signed [ValueW-1:0] ld_value;
  status_e                  ld_status;
  logic                     ld_last;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_mode  = mode_e'(s_axis_tuser_i);
  assign in_value = s_axis_tdata_i[31:0];
  assign in_pos   = s_axis_tdata_i[39:32];

  // Cell chain.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [ValueW-1:0] left_v, right_v;
    if (k == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[k+1];
    end
    bcle_cell #(.IDX(k)) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .left_i  (left_v),
      .right_i (right_v),
      .head_i  (cell_value[0]),
      .value_o (cell_value[k])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_left_d = rd_left_q;
    cell_cmd  = '{op: OP_HOLD, idx: '0, value: '0};
    ld        = 1'b0;
    ld_value  = '0;
    ld_status = STAT_OK;
    ld_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          ld = 1'b1;
          unique case (in_mode)
            MODE_INS_FRONT, MODE_INS_END: begin
              if (count_q == Full) begin
                ld_status = STAT_FULL;
              end else begin
                count_d = count_q + 1'b1;
                if (in_mode == MODE_INS_FRONT) begin
                  cell_cmd = '{op: OP_PUSH_FRONT, idx: '0, value: in_value};
                end else begin
                  cell_cmd = '{op: OP_APPEND, idx: IdxW'(count_q), value: in_value};
                end
              end
            end
            MODE_DEL_FRONT: begin
              if (count_q == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                count_d  = count_q - 1'b1;
                cell_cmd = '{op: OP_CLOSE_GAP, idx: '0, value: '0};
              end
            end
            MODE_DEL_END: begin
              // The tail cell is simply dropped from the occupied run.
              if (count_q == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            MODE_DEL_POS: begin
              if (count_q == '0) begin
                ld_status = STAT_EMPTY;
              end else if (in_pos == '0 || CMP_W'(in_pos) > CMP_W'(count_q)) begin
                ld_status = STAT_RANGE;
              end else begin
                count_d  = count_q - 1'b1;
                cell_cmd = '{op: OP_CLOSE_GAP, idx: IdxW'(in_pos - 1'b1), value: '0};
              end
            end
            MODE_READ_OUT: begin
              if (count_q == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                ld        = 1'b0;
                rd_left_d = count_q;
                state_d   = S_READ;
              end
            end
            default: begin
              ld_status = STAT_OK;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_value  = cell_value[0];
          ld_last   = (rd_left_q == CW'(1));
          rd_left_d = rd_left_q - 1'b1;
          cell_cmd  = '{op: OP_ROTATE, idx: IdxW'(count_q - 1'b1), value: '0};
          if (ld_last) state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d  = ld ? 1'b1 : (out_valid_q && !m_axis_tready_i);
    out_value_d  = ld ? ld_value : out_value_q;
    out_status_d = ld ? ld_status : out_status_q;
    out_held_d   = ld ? HeldW'(count_d) : out_held_q;
    out_last_d   = ld ? ld_last : out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_held_q   <= out_held_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_held_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above capacity");

  // While reading out, at least one result is still owed.
  a_read_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (rd_left_q != '0))
    else $error("read out with nothing left to emit");

  // The final read-out result carries the end-of-run mark.
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && out_free && rd_left_q == CW'(1)) |=>
      (out_valid_q && out_last_q && state_q == S_IDLE))
    else $error("read out ended without a marked last result");

  // A read out does not change the number of entries.
  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> $stable(count_q))
    else $error("entry count changed during read out");

endmodule

`default_nettype wire

@@ src/bcle_cell.sv @@
// One list cell: holds the entry at a fixed list position and trades it with its neighbors.
`default_nettype none

module bcle_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                                       clk_i,
  input  wire bcle_pkg::cell_cmd_t                  cmd_i,
  input  wire logic signed [bcle_pkg::ValueW-1:0]   left_i,
  input  wire logic signed [bcle_pkg::ValueW-1:0]   right_i,
  input  wire logic signed [bcle_pkg::ValueW-1:0]   head_i,
  output logic signed [bcle_pkg::ValueW-1:0]        value_o
);
  import bcle_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  logic signed [ValueW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (cmd_i.op)
      OP_HOLD: begin
        value_d = value_q;
      end
      OP_PUSH_FRONT: begin
        value_d = (MyIdx == '0) ? cmd_i.value : left_i;
      end
      OP_APPEND: begin
        if (MyIdx == cmd_i.idx) value_d = cmd_i.value;
      end
      OP_CLOSE_GAP: begin
        if (MyIdx >= cmd_i.idx) value_d = right_i;
      end
      OP_ROTATE: begin
        // The head entry wraps around to the tail position of the occupied run.
        if (MyIdx < cmd_i.idx) begin
          value_d = right_i;
        end else if (MyIdx == cmd_i.idx) begin
          value_d = head_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

@@ sim/tb_bounded_circular_list_engine_core.sv @@
// Testbench for the bounded circular list engine: directed and random list operations.
module tb_bounded_circular_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bcle_pkg::*;

  localparam int unsigned ListDepth = 16;
  localparam int unsigned RandomOps = 150;
  localparam int unsigned CycleLimit = 400000;
  // Mode codes that the block does not use; they must leave the list alone.
  localparam logic [ModeW-1:0] ModeSpareA = 3'd6;
  localparam logic [ModeW-1:0] ModeSpareB = 3'd7;

  typedef struct {
    logic [ValueW-1:0]  item_value;
    logic [StatusW-1:0] status;
    logic [HeldW-1:0]   held;
    logic               last;
  } list_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [39:0] m_tdata;
  wire  [1:0]  m_tuser;
  wire         m_tlast;

  // Entries in list order, head first.
  logic signed [ValueW-1:0] list_entries[$];
  list_result_t             expected_results[$];
  int unsigned              fail_count = 0;
  int unsigned              cycle_count = 0;
  int unsigned              stall_left = 0;
  bit                       quiet_run = 1'b0;

  bounded_circular_list_engine_core #(
    .DEPTH(ListDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Applies one operation to the list and queues the results it must produce.
  function automatic void apply_list_op(logic [2:0] mode, logic [31:0] value,
                                        logic [7:0] pos);
    list_result_t res;
    status_e      st;
    int           n;
    n = list_entries.size();
    st = STAT_OK;
    res.item_value = '0;
    res.last = 1'b1;
    if (mode == MODE_READ_OUT) begin
      if (n == 0) begin
        res.status = STAT_EMPTY;
        res.held = '0;
        expected_results.push_back(res);
      end else begin
        for (int k = 0; k < n; k++) begin
          res.item_value = list_entries[k];
          res.status = STAT_OK;
          res.held = n[HeldW-1:0];
          res.last = (k == n - 1);
          expected_results.push_back(res);
        end
      end
      return;
    end
    case (mode)
      MODE_INS_FRONT, MODE_INS_END: begin
        if (n >= ListDepth) st = STAT_FULL;
        else if (mode == MODE_INS_FRONT) list_entries.push_front(value);
        else list_entries.push_back(value);
      end
      MODE_DEL_FRONT: begin
        if (n == 0) st = STAT_EMPTY;
        else void'(list_entries.pop_front());
      end
      MODE_DEL_END: begin
        if (n == 0) st = STAT_EMPTY;
        else void'(list_entries.pop_back());
      end
      MODE_DEL_POS: begin
        if (n == 0) st = STAT_EMPTY;
        else if (pos == 0 || pos > n) st = STAT_RANGE;
        else list_entries.delete(int'(pos) - 1);
      end
      default: begin
      end
    endcase
    res.status = st;
    res.held = HeldW'(list_entries.size());
    expected_results.push_back(res);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Result checker: every transfer on the output side is matched with the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %h tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("item_value", want.item_value, m_tdata[31:0]);
        check_field("entries_held", 32'(want.held), 32'(m_tdata[36:32]));
        check_field("tdata padding", 32'd0, 32'(m_tdata[39:37]));
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("last_of_run", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  // Receiver: after each transfer it may stall for a random number of cycles, none in a quiet run.
  always @(posedge clk_i) begin
    int unsigned stall;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (m_tready && m_tvalid) begin
      stall = quiet_run ? 0 : $urandom_range(0, 9);
      stall_left <= stall;
      m_tready <= (stall == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Sends one operation; valid stays high afterwards so back-to-back transfers need no toggle.
  task automatic send_op(input logic [2:0] mode, input logic [31:0] value,
                         input logic [7:0] pos);
    int unsigned gap;
    gap = quiet_run ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {pos, value};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    apply_list_op(mode, value, pos);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h8000_0000;
    if (r < 6) return 32'h7FFF_FFFF;
    if (r < 8) return 32'hFFFF_FFFF;
    if (r < 10) return 32'h0000_0000;
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_position();
    int unsigned r;
    int unsigned n;
    n = list_entries.size();
    r = $urandom_range(0, 99);
    if (n > 0 && r < 70) return 8'($urandom_range(1, n));
    if (r < 80) return 8'd0;
    if (r < 90) return 8'($urandom_range(n + 1, n + 8));
    return 8'($urandom_range(0, 255));
  endfunction

  // Picks a mode leaning toward inserts when growing and toward deletes otherwise.
  function automatic logic [2:0] pick_mode(bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 35) return MODE_INS_FRONT;
      if (r < 70) return MODE_INS_END;
      if (r < 77) return MODE_DEL_FRONT;
      if (r < 84) return MODE_DEL_END;
      if (r < 92) return MODE_DEL_POS;
      if (r < 98) return MODE_READ_OUT;
    end else begin
      if (r < 12) return MODE_INS_FRONT;
      if (r < 24) return MODE_INS_END;
      if (r < 44) return MODE_DEL_FRONT;
      if (r < 64) return MODE_DEL_END;
      if (r < 88) return MODE_DEL_POS;
      if (r < 96) return MODE_READ_OUT;
    end
    return ($urandom_range(0, 1) == 0) ? ModeSpareA : ModeSpareB;
  endfunction

  // Operations on an empty list, unused modes, extreme values and every kind of delete.
  task automatic test_edge_cases();
    send_op(MODE_READ_OUT, 32'd0, 8'd0);
    send_op(MODE_DEL_FRONT, 32'd0, 8'd0);
    send_op(MODE_DEL_END, 32'd0, 8'd0);
    send_op(MODE_DEL_POS, 32'd0, 8'd0);
    send_op(MODE_DEL_POS, 32'd0, 8'hFF);
    send_op(ModeSpareA, 32'd0, 8'd0);
    send_op(ModeSpareB, 32'hFFFF_FFFF, 8'hFF);
    send_op(MODE_INS_FRONT, 32'h8000_0000, 8'd0);
    send_op(MODE_INS_END, 32'h7FFF_FFFF, 8'd0);
    send_op(MODE_INS_FRONT, 32'h0000_0000, 8'd0);
    send_op(MODE_INS_END, 32'hFFFF_FFFF, 8'd0);
    send_op(ModeSpareA, 32'h1234_5678, 8'd1);
    send_op(MODE_READ_OUT, 32'd0, 8'd0);
    send_op(MODE_DEL_POS, 32'd0, 8'd0);
    send_op(MODE_DEL_POS, 32'd0, 8'd5);
    send_op(MODE_DEL_POS, 32'd0, 8'hFF);
    // Removing the final entry by position is legal.
    send_op(MODE_DEL_POS, 32'd0, 8'd4);
    send_op(MODE_DEL_POS, 32'd0, 8'd2);
    send_op(MODE_READ_OUT, 32'd0, 8'd0);
    send_op(MODE_DEL_END, 32'd0, 8'd0);
    send_op(MODE_DEL_FRONT, 32'd0, 8'd0);
    send_op(MODE_INS_END, 32'h0000_0005, 8'd0);
    send_op(MODE_DEL_POS, 32'd0, 8'd1);
  endtask

  // Fills the list to capacity, pushes past it, then drains it below empty.
  task automatic test_full_and_empty();
    logic [2:0] mode;
    while (list_entries.size() < ListDepth) begin
      mode = ($urandom_range(0, 1) == 0) ? MODE_INS_FRONT : MODE_INS_END;
      send_op(mode, pick_value(), 8'($urandom()));
    end
    send_op(MODE_INS_FRONT, pick_value(), 8'd0);
    send_op(MODE_INS_END, pick_value(), 8'd0);
    send_op(MODE_READ_OUT, 32'd0, 8'd0);
    send_op(MODE_DEL_POS, 32'd0, 8'd17);
    send_op(MODE_DEL_POS, 32'd0, 8'd16);
    send_op(MODE_INS_END, pick_value(), 8'd0);
    while (list_entries.size() > 0) begin
      case ($urandom_range(0, 2))
        0: send_op(MODE_DEL_FRONT, $urandom(), 8'($urandom()));
        1: send_op(MODE_DEL_END, $urandom(), 8'($urandom()));
        default: send_op(MODE_DEL_POS, $urandom(),
                         8'($urandom_range(1, list_entries.size())));
      endcase
    end
    send_op(MODE_DEL_END, 32'd0, 8'd0);
    send_op(MODE_READ_OUT, 32'd0, 8'd0);
  endtask

  // The sender holds off until every pending result has been taken.
  task automatic test_pause_for_results();
    for (int round = 0; round < 2; round++) begin
      for (int k = 0; k < 8; k++) send_op(pick_mode(round == 0), pick_value(), pick_position());
      send_op(MODE_READ_OUT, 32'd0, 8'd0);
      stop_sending();
      wait_all_results();
    end
  endtask

  // Random operations in blocks that lean toward growing or shrinking the list.
  task automatic test_random_mix();
    bit grow;
    grow = 1'b1;
    for (int k = 0; k < RandomOps; k++) begin
      if (k % 15 == 0) begin
        grow = (list_entries.size() < ListDepth / 2) ? ($urandom_range(0, 3) != 0)
                                                      : ($urandom_range(0, 3) == 0);
        quiet_run = ($urandom_range(0, 3) == 0);
      end
      send_op(pick_mode(grow), pick_value(), pick_position());
    end
    quiet_run = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    test_full_and_empty();
    test_pause_for_results();
    test_random_mix();
    stop_sending();
    wait_all_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
